### rtl/xor_checked_hex_frame_receiver_core_defines.svh
// Assertion macros used by the frame receiver checker.
`ifndef XOR_CHECKED_HEX_FRAME_RECEIVER_CORE_DEFINES_SVH
`define XOR_CHECKED_HEX_FRAME_RECEIVER_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define XHFR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define XHFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/xhfr_pkg.sv
// Types and constants of the XOR-checked hex frame receiver.
package xhfr_pkg;

   localparam int FRAME_CAPACITY_DEFAULT = 1024;
   localparam logic [7:0] DELIMITER_RESET = 8'h24;

   typedef enum logic [1:0] {
      STATUS_GOOD      = 2'd0,
      STATUS_MISMATCH  = 2'd1,
      STATUS_BAD_HEX   = 2'd2,
      STATUS_TOO_SHORT = 2'd3
   } status_type;

   // Summary of the frame held at the moment its delimiter arrives.
   typedef struct packed {
      logic       too_short;
      logic [9:0] payload_length;
      logic [7:0] older_xor;
      logic [7:0] digit_hi;
      logic [7:0] digit_lo;
   } frame_type;

   typedef struct packed {
      status_type frame_status;
      logic [9:0] payload_length;
      logic [7:0] received_checksum;
      logic [7:0] computed_checksum;
   } result_type;

endpackage

### rtl/xhfr_if.sv
// Valid/ready channel interfaces for received bytes and frame results.
interface xhfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface xhfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] frame_status;
   logic [9:0] payload_length;
   logic [7:0] received_checksum;
   logic [7:0] computed_checksum;

   modport source (
      output valid, output frame_status, output payload_length,
      output received_checksum, output computed_checksum, input ready
   );
   modport sink (
      input valid, input frame_status, input payload_length,
      input received_checksum, input computed_checksum, output ready
   );
endinterface

### rtl/xor_checked_hex_frame_receiver_core.sv
// Receiver that frames serial bytes on a delimiter and checks a hex XOR checksum.
// Throughput: one byte transfer per cycle while no held result is stalled by the sink.
// Latency: a frame result is valid in the cycle after its delimiter transfer.
// The receiver takes a new byte while a held result is being taken (ready follows rsp).
// Reset (synchronous, high) clears the frame state and result valid, delimiter back to '$'.
module xor_checked_hex_frame_receiver_core import xhfr_pkg::*; #(
   parameter int FRAME_CAPACITY = FRAME_CAPACITY_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   xhfr_req_if.sink    req_bus,
   xhfr_rsp_if.source  rsp_bus,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data
);

   // Count never reaches the capacity, so it fits in clog2 bits.
   localparam int CountWidth = $clog2(FRAME_CAPACITY);

   logic [CountWidth-1:0] count_ff, count_in;
   logic [CountWidth:0]   count_inc;
   logic [7:0]            older_xor_ff, older_xor_in;
   logic [7:0]            recent_hi_ff, recent_hi_in;   // second most recent byte
   logic [7:0]            recent_lo_ff, recent_lo_in;   // most recent byte
   logic [7:0]            delimiter_ff, delimiter_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_data_ff;

   logic       req_transfer;
   logic       is_delimiter;
   logic       rsp_load;
   frame_type  frame;
   result_type result;

   // Accept a byte whenever reset is low and the result register is free or is being emptied.
   assign req_bus.ready = !reset && (!rsp_valid_ff || rsp_bus.ready);
   assign req_transfer  = req_bus.valid && req_bus.ready;
   assign is_delimiter  = (req_bus.rx_byte == delimiter_ff);
   assign count_inc     = (CountWidth + 1)'(count_ff) + (CountWidth + 1)'(1);

   // An empty frame closes silently; any other delimiter loads a result.
   assign rsp_load = req_transfer && is_delimiter && (count_ff != '0);

   // Snapshot of the current frame for the checksum evaluation.
   always_comb begin
      frame.too_short      = (count_ff == CountWidth'(1));
      frame.payload_length = 10'(count_ff - CountWidth'(2));
      frame.older_xor      = older_xor_ff;
      frame.digit_hi       = recent_hi_ff;
      frame.digit_lo       = recent_lo_ff;
   end

   xhfr_frame_eval u_frame_eval (
      .frame  (frame),
      .result (result)
   );

   // Frame state update: shift a byte in, fold the oldest into the XOR, or clear the frame.
   always_comb begin
      count_in     = count_ff;
      older_xor_in = older_xor_ff;
      recent_hi_in = recent_hi_ff;
      recent_lo_in = recent_lo_ff;
      if (req_transfer) begin
         if (is_delimiter) begin
            // Drop the frame after reporting it.
            count_in     = '0;
            older_xor_in = 8'd0;
            recent_hi_in = 8'd0;
            recent_lo_in = 8'd0;
         end else if (count_inc == (CountWidth + 1)'(FRAME_CAPACITY)) begin
            // Frame overflow: discard without a result.
            count_in     = '0;
            older_xor_in = 8'd0;
            recent_hi_in = 8'd0;
            recent_lo_in = 8'd0;
         end else begin
            if (count_ff >= CountWidth'(2)) begin
               older_xor_in = older_xor_ff ^ recent_hi_ff;
            end
            recent_hi_in = recent_lo_ff;
            recent_lo_in = req_bus.rx_byte;
            count_in     = count_inc[CountWidth-1:0];
         end
      end
   end

   // Hold a result until the sink takes it; a new load may replace a taken one.
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign delimiter_in = csr_write_enable ? csr_write_data : delimiter_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         older_xor_ff <= 8'd0;
         recent_hi_ff <= 8'd0;
         recent_lo_ff <= 8'd0;
         delimiter_ff <= DELIMITER_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         older_xor_ff <= older_xor_in;
         recent_hi_ff <= recent_hi_in;
         recent_lo_ff <= recent_lo_in;
         delimiter_ff <= delimiter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload needs no reset; it is qualified by the valid register.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.frame_status      = rsp_data_ff.frame_status;
   assign rsp_bus.payload_length    = rsp_data_ff.payload_length;
   assign rsp_bus.received_checksum = rsp_data_ff.received_checksum;
   assign rsp_bus.computed_checksum = rsp_data_ff.computed_checksum;

endmodule

### rtl/xhfr_frame_eval.sv
// Decodes the trailing hex digits of a closed frame and grades its checksum.
module xhfr_frame_eval import xhfr_pkg::*; (
   input  frame_type  frame,
   output result_type result
);

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } nibble_type;

   function automatic nibble_type hex_nibble(input logic [7:0] c);
      nibble_type n;
      n.ok    = 1'b1;
      n.value = 4'd0;
      if (c inside {[8'h30:8'h39]}) begin
         n.value = 4'(c - 8'h30);
      end else if (c inside {[8'h41:8'h46]}) begin
         n.value = 4'(c - 8'h37);
      end else if (c inside {[8'h61:8'h66]}) begin
         n.value = 4'(c - 8'h57);
      end else begin
         n.ok = 1'b0;
      end
      return n;
   endfunction

   nibble_type hi;
   nibble_type lo;
   logic [7:0] rx_value;

   assign hi       = hex_nibble(frame.digit_hi);
   assign lo       = hex_nibble(frame.digit_lo);
   assign rx_value = {hi.value, lo.value};

   always_comb begin
      result.frame_status      = STATUS_GOOD;
      result.payload_length    = frame.payload_length;
      result.received_checksum = 8'd0;
      result.computed_checksum = frame.older_xor;
      if (frame.too_short) begin
         result.frame_status      = STATUS_TOO_SHORT;
         result.payload_length    = 10'd0;
         result.computed_checksum = 8'd0;
      end else if (!hi.ok || !lo.ok) begin
         result.frame_status = STATUS_BAD_HEX;
      end else begin
         result.received_checksum = rx_value;
         result.frame_status = (rx_value == frame.older_xor) ? STATUS_GOOD : STATUS_MISMATCH;
      end
   end

endmodule

### rtl/xhfr_checker.sv
// Port-level checker for the frame receiver, bound to the top level.
`include "xor_checked_hex_frame_receiver_core_defines.svh"

module xhfr_checker import xhfr_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_frame_status,
   input logic [9:0] rsp_payload_length,
   input logic [7:0] rsp_received_checksum,
   input logic [7:0] rsp_computed_checksum
);

   `XHFR_ASSERT_NEXT(rsp_hold_a, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_frame_status) && $stable(rsp_payload_length) && $stable(rsp_received_checksum) && $stable(rsp_computed_checksum), "result changed while stalled")

   `XHFR_ASSERT_SAME(rsp_cause_a, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready), "result without a byte transfer")

   `XHFR_ASSERT_SAME(short_zero_a, clock, reset, rsp_valid && rsp_frame_status == STATUS_TOO_SHORT, rsp_payload_length == 10'd0 && rsp_received_checksum == 8'd0 && rsp_computed_checksum == 8'd0, "short frame with nonzero fields")

   `XHFR_ASSERT_SAME(bad_hex_zero_a, clock, reset, rsp_valid && rsp_frame_status == STATUS_BAD_HEX, rsp_received_checksum == 8'd0, "bad hex frame with nonzero checksum")

   `XHFR_ASSERT_SAME(good_match_a, clock, reset, rsp_valid && rsp_frame_status == STATUS_GOOD, rsp_received_checksum == rsp_computed_checksum, "good frame with differing checksums")

endmodule

bind xor_checked_hex_frame_receiver_core xhfr_checker u_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_bus.valid),
   .req_ready             (req_bus.ready),
   .rsp_valid             (rsp_bus.valid),
   .rsp_ready             (rsp_bus.ready),
   .rsp_frame_status      (rsp_bus.frame_status),
   .rsp_payload_length    (rsp_bus.payload_length),
   .rsp_received_checksum (rsp_bus.received_checksum),
   .rsp_computed_checksum (rsp_bus.computed_checksum)
);

### sim/tb_xor_checked_hex_frame_receiver_core.sv
// Self-checking testbench for the XOR-checked hex frame receiver core.
module tb_xor_checked_hex_frame_receiver_core;
   timeunit 1ns;
   timeprecision 1ps;
   import xhfr_pkg::*;

   // Cycles in a row with no transfer of any kind before the run is abandoned.
   localparam int WATCHDOG_LIMIT     = 3000;
   // Length of the deliberate result-side hold-off.
   localparam int HOLD_OFF_CYCLES    = 80;
   // Spare cycles after the last expected result, before a register write.
   localparam int SETTLE_CYCLES      = 4;
   localparam int RANDOM_PHASE_ITEMS = 105;
   localparam int REPORT_LIMIT       = 10;

   typedef enum int {
      MIX_STEADY,
      MIX_SENDER_GAPS,
      MIX_RECEIVER_STALLS,
      MIX_BOTH_SPARSE
   } traffic_mix_type;

   // What follows the payload of a generated frame.
   typedef enum int {
      TAIL_GOOD,
      TAIL_WRONG,
      TAIL_BAD_DIGIT,
      TAIL_NONE
   } frame_tail_type;

   // One row of the directed table; want is used only when pinned is set.
   typedef struct packed {
      logic [7:0] rx_byte;
      bit         pinned;
      result_type want;
   } byte_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic [7:0] csr_write_data;

   xhfr_req_if req_bus ();
   xhfr_rsp_if rsp_bus ();

   xor_checked_hex_frame_receiver_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Stimulus-side view of the delimiter, used to build well-formed frames.
   logic [7:0]      current_delim = DELIMITER_RESET;
   traffic_mix_type traffic_mix = MIX_STEADY;

   // Typed-in expectation that travels with the byte on the request channel.
   bit         pin_valid;
   result_type pin_want;

   // Frame model: delimiter copy, byte count, XOR of older bytes, last two bytes.
   logic [7:0] model_delim = DELIMITER_RESET;
   int         model_count;
   logic [7:0] model_older_xor;
   logic [7:0] model_recent [2];

   result_type frame_results_q [$];

   int bytes_sent;
   int results_checked;
   int delimiter_writes;
   int failures;
   int idle_streak;

   bit hold_off_request;
   int hold_off_left;

   // ------------------------------------------------------------------
   // Frame model
   // ------------------------------------------------------------------

   function automatic void restart_frame_model();
      model_count     = 0;
      model_older_xor = 8'h00;
      model_recent[0] = 8'h00;
      model_recent[1] = 8'h00;
   endfunction

   // Nibble value of a hex digit in either case; 16 marks a non-digit.
   function automatic logic [4:0] digit_value(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
      if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h41 + 8'd10);
      if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h61 + 8'd10);
      return 5'd16;
   endfunction

   // Advance the model by one byte; return 1 when the byte closes a reportable frame.
   function automatic bit advance_frame_model(input logic [7:0] b, output result_type r);
      logic [4:0] hi;
      logic [4:0] lo;
      logic [7:0] rx;
      r = '0;
      if (b != model_delim) begin
         if (model_count >= 2) model_older_xor = model_older_xor ^ model_recent[0];
         model_recent[0] = model_recent[1];
         model_recent[1] = b;
         model_count++;
         // Drop the whole frame once it hits capacity.
         if (model_count >= FRAME_CAPACITY_DEFAULT) restart_frame_model();
         return 1'b0;
      end
      if (model_count == 0) return 1'b0;
      if (model_count < 2) begin
         r.frame_status = STATUS_TOO_SHORT;
      end else begin
         hi = digit_value(model_recent[0]);
         lo = digit_value(model_recent[1]);
         r.payload_length    = 10'(model_count - 2);
         r.computed_checksum = model_older_xor;
         if (hi[4] || lo[4]) begin
            r.frame_status = STATUS_BAD_HEX;
         end else begin
            rx = {hi[3:0], lo[3:0]};
            r.received_checksum = rx;
            r.frame_status = (rx == model_older_xor) ? STATUS_GOOD : STATUS_MISMATCH;
         end
      end
      restart_frame_model();
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // Traffic shaping
   // ------------------------------------------------------------------

   function automatic bit sender_idles();
      case (traffic_mix)
         MIX_SENDER_GAPS: return $urandom_range(99) < 71;
         MIX_BOTH_SPARSE: return $urandom_range(99) < 15;
         default:         return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_stalls();
      case (traffic_mix)
         MIX_RECEIVER_STALLS: return $urandom_range(99) < 71;
         MIX_BOTH_SPARSE:     return $urandom_range(99) < 15;
         default:             return 1'b0;
      endcase
   endfunction

   // Result side: drive ready at the falling edge. A requested hold-off is
   // counted down here, independent of what the sender is doing.
   always @(negedge clock) begin
      if (hold_off_request) begin
         hold_off_left    = HOLD_OFF_CYCLES;
         hold_off_request = 1'b0;
      end
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= !receiver_stalls();
      end
   end

   // ------------------------------------------------------------------
   // Monitor: predict on byte transfers, check on result transfers
   // ------------------------------------------------------------------

   always @(posedge clock) begin : monitor
      result_type got;
      result_type want;
      result_type predicted;
      bit         produced;
      bit         activity;
      if (reset) begin
         restart_frame_model();
         model_delim = DELIMITER_RESET;
         idle_streak = 0;
      end else begin
         activity = 1'b0;

         // Check the result first: it always belongs to an earlier delimiter.
         if (rsp_bus.valid && rsp_bus.ready) begin
            activity = 1'b1;
            got.frame_status      = status_type'(rsp_bus.frame_status);
            got.payload_length    = rsp_bus.payload_length;
            got.received_checksum = rsp_bus.received_checksum;
            got.computed_checksum = rsp_bus.computed_checksum;
            if (frame_results_q.size() == 0) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("unexpected frame result: status %0d len %0d rx %h calc %h",
                           got.frame_status, got.payload_length,
                           got.received_checksum, got.computed_checksum);
            end else begin
               want = frame_results_q.pop_front();
               results_checked++;
               if (got.frame_status !== want.frame_status ||
                   got.payload_length !== want.payload_length ||
                   got.received_checksum !== want.received_checksum ||
                   got.computed_checksum !== want.computed_checksum) begin
                  failures++;
                  if (failures <= REPORT_LIMIT) begin
                     $display("frame result %0d mismatch: expected status %0d len %0d rx %h calc %h",
                              results_checked, want.frame_status, want.payload_length,
                              want.received_checksum, want.computed_checksum);
                     $display("   got status %0d len %0d rx %h calc %h",
                              got.frame_status, got.payload_length,
                              got.received_checksum, got.computed_checksum);
                  end
               end
            end
         end

         // Track the delimiter register exactly at the edge that writes it.
         if (csr_write_enable) begin
            activity = 1'b1;
            model_delim = csr_write_data;
            delimiter_writes++;
         end

         // Advance the model on each byte transfer; a pinned row overrides it.
         if (req_bus.valid && req_bus.ready) begin
            activity = 1'b1;
            produced = advance_frame_model(req_bus.rx_byte, predicted);
            if (pin_valid)
               frame_results_q.push_back(pin_want);
            else if (produced)
               frame_results_q.push_back(predicted);
         end

         if (activity) begin
            idle_streak = 0;
         end else begin
            idle_streak++;
            if (idle_streak >= WATCHDOG_LIMIT) begin
               $display("watchdog: no transfer for %0d cycles, %0d results pending",
                        idle_streak, frame_results_q.size());
               $display("[FAIL] regression broken");
               $finish;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   // Offer one byte from the falling edge and hold it until the transfer.
   task automatic send_byte(input logic [7:0] b, input bit pinned, input result_type want);
      @(negedge clock);
      while (sender_idles()) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      pin_valid       <= pinned;
      pin_want        <= want;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      bytes_sent++;
   endtask

   function automatic logic [7:0] random_data_byte();
      logic [7:0] b;
      b = 8'($urandom_range(255));
      while (b == current_delim) b = 8'($urandom_range(255));
      return b;
   endfunction

   function automatic logic [7:0] random_non_digit();
      logic [7:0] b;
      b = 8'($urandom_range(255));
      while (digit_value(b) != 5'd16 || b == current_delim) b = 8'($urandom_range(255));
      return b;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
      if (n < 4'd10) return 8'h30 + 8'(n);
      return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
   endfunction

   // Payload of random data bytes, an optional two-character tail, then the delimiter.
   task automatic send_frame(input int n_payload, input frame_tail_type tail);
      logic [7:0] sum;
      logic [7:0] b;
      logic [7:0] tag;
      logic [7:0] hi_c;
      logic [7:0] lo_c;
      int         i;
      sum = 8'h00;
      for (i = 0; i < n_payload; i++) begin
         b = random_data_byte();
         sum ^= b;
         send_byte(b, 1'b0, '0);
      end
      tag = (tail == TAIL_WRONG) ? (sum ^ 8'($urandom_range(1, 255))) : sum;
      hi_c = hex_char(tag[7:4], 1'($urandom_range(1)));
      lo_c = hex_char(tag[3:0], 1'($urandom_range(1)));
      if (tail == TAIL_BAD_DIGIT) begin
         case ($urandom_range(2))
            0:       hi_c = random_non_digit();
            1:       lo_c = random_non_digit();
            default: begin
               hi_c = random_non_digit();
               lo_c = random_non_digit();
            end
         endcase
      end
      if (tail != TAIL_NONE) begin
         send_byte(hi_c, 1'b0, '0);
         send_byte(lo_c, 1'b0, '0);
      end
      send_byte(current_delim, 1'b0, '0);
   endtask

   // Mostly well-formed frames with random content, plus broken ones and noise.
   task automatic send_random_frame();
      int pick;
      int len;
      pick = $urandom_range(99);
      len  = ($urandom_range(7) == 0) ? $urandom_range(9, 48) : $urandom_range(0, 8);
      if (pick < 58) begin
         send_frame(len, TAIL_GOOD);
      end else if (pick < 70) begin
         send_frame(len, TAIL_WRONG);
      end else if (pick < 80) begin
         send_frame(len, TAIL_BAD_DIGIT);
      end else if (pick < 88) begin
         // One lone byte and a delimiter, or a bare delimiter.
         send_frame($urandom_range(1), TAIL_NONE);
      end else begin
         repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)), 1'b0, '0);
      end
   endtask

   task automatic run_random_phase(input int items);
      int target;
      target = bytes_sent + items;
      while (bytes_sent < target) send_random_frame();
   endtask

   // Drop valid, let every expected result arrive, then wait out the settle margin.
   task automatic drain_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (frame_results_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_delimiter(input logic [7:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      current_delim     = value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   byte_row_type directed_rows [$];

   task automatic add_row(input logic [7:0] b);
      byte_row_type row;
      row = '{rx_byte: b, pinned: 1'b0, want: '0};
      directed_rows.push_back(row);
   endtask

   task automatic add_checked_row(input logic [7:0] b, input status_type s,
                                  input logic [9:0] len, input logic [7:0] rx,
                                  input logic [7:0] calc);
      byte_row_type row;
      row.rx_byte = b;
      row.pinned  = 1'b1;
      row.want.frame_status      = s;
      row.want.payload_length    = len;
      row.want.received_checksum = rx;
      row.want.computed_checksum = calc;
      directed_rows.push_back(row);
   endtask

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = 8'h00;
      req_bus.valid    = 1'b0;
      req_bus.rx_byte  = 8'h00;
      rsp_bus.ready    = 1'b0;
      pin_valid        = 1'b0;
      pin_want         = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Directed table under the reset delimiter '$'.
      add_row(8'h24);                                            // empty frame: no result
      add_row(8'h41);                                            // 'A'
      add_checked_row(8'h24, STATUS_TOO_SHORT, 10'd0, 8'h00, 8'h00);
      add_row(8'h30);                                            // "00": empty payload
      add_row(8'h30);
      add_checked_row(8'h24, STATUS_GOOD, 10'd0, 8'h00, 8'h00);
      add_row(8'h67);                                            // 'g' is no digit
      add_row(8'h30);
      add_checked_row(8'h24, STATUS_BAD_HEX, 10'd0, 8'h00, 8'h00);
      add_row(8'hFF);                                            // byte extremes, "FF"
      add_row(8'h00);
      add_row(8'h46);
      add_row(8'h46);
      add_checked_row(8'h24, STATUS_GOOD, 10'd2, 8'hFF, 8'hFF);
      add_row(8'h12);                                            // "13" against 0x12
      add_row(8'h31);
      add_row(8'h33);
      add_checked_row(8'h24, STATUS_MISMATCH, 10'd1, 8'h13, 8'h12);
      add_row(8'hAB);                                            // lower-case "ab"
      add_row(8'h61);
      add_row(8'h62);
      add_checked_row(8'h24, STATUS_GOOD, 10'd1, 8'hAB, 8'hAB);
      add_row(8'h39);                                            // '9' then 'G': bad low digit
      add_row(8'h47);
      add_row(8'h24);

      traffic_mix = MIX_STEADY;
      foreach (directed_rows[i])
         send_byte(directed_rows[i].rx_byte, directed_rows[i].pinned, directed_rows[i].want);
      drain_results();

      // Random phases, each under its own delimiter and handshake mix.
      write_delimiter(8'h00);
      traffic_mix = MIX_SENDER_GAPS;
      run_random_phase(RANDOM_PHASE_ITEMS);
      drain_results();

      write_delimiter(8'hFF);
      traffic_mix = MIX_RECEIVER_STALLS;
      run_random_phase(RANDOM_PHASE_ITEMS);
      drain_results();

      write_delimiter(8'($urandom_range(255)));
      traffic_mix = MIX_BOTH_SPARSE;
      run_random_phase(RANDOM_PHASE_ITEMS);
      drain_results();

      // Hold off the result side while bytes keep coming, so the input backs up.
      write_delimiter(8'h24);
      traffic_mix = MIX_STEADY;
      hold_off_request = 1'b1;
      run_random_phase(RANDOM_PHASE_ITEMS);
      drain_results();

      write_delimiter(8'h0A);
      traffic_mix = MIX_SENDER_GAPS;
      run_random_phase(RANDOM_PHASE_ITEMS);
      drain_results();

      repeat (8) @(posedge clock);

      if (frame_results_q.size() != 0) begin
         failures += frame_results_q.size();
         $display("%0d expected frame results never arrived", frame_results_q.size());
      end
      $display("covered %0d byte transfers, %0d frame results, %0d delimiter writes",
               bytes_sent, results_checked, delimiter_writes);
      $display("mixes: steady, sender gaps, receiver stalls, sparse; long result hold-off");
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d failures", failures);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
